FILE: hdl/iqau_pkg.sv
// Shared types and constants for the quaternion attitude update block.
package iqau_pkg;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic [23:0] GAIN_RESET = 24'd32768;
    // Control for the serial divider.
    typedef struct packed {
        logic        start;
        logic [63:0] num_mag;
        logic [63:0] den;
    } t_div_req;
endpackage

FILE: hdl/imu_quaternion_attitude_update_top.sv
// Quaternion attitude update: proportional complementary filter on one IMU sample per transaction.
// Per sample, two 32-step square roots and seven 64-step divisions on a shared serial divider
// run, with sequenced multiply/accumulate on one 33x33 multiplier in between. A zero
// accelerometer vector skips the three accel divisions; a zero quaternion norm skips the four
// renormalizing divisions. The result is held in an output register while the next sample is
// accepted and processed; that sample's result waits in the last stage until the register is
// free, and no further sample is taken meanwhile. The user must see that error_gain is written
// through i_cfg_we/i_cfg_data only while idle; the block itself does not enforce it.
module imu_quaternion_attitude_update_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [23:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], rate_x[79:48], rate_y[111:80],
    // rate_z[143:112], step_time[167:144]
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // att_w[31:0], att_x[63:32], att_y[95:64], att_z[127:96]
    output logic [127:0] m_axis_tdata
);
    localparam logic [4:0] S_IDLE = 5'd0, S_ASUM = 5'd1, S_ASQ = 5'd2, S_ADIV = 5'd3,
        S_ADW = 5'd4, S_V = 5'd5, S_E = 5'd6, S_G = 5'd7, S_S = 5'd8, S_INC = 5'd9,
        S_QSUM = 5'd10, S_QSQ = 5'd11, S_QDIV = 5'd12, S_QDW = 5'd13, S_OUT = 5'd14,
        S_SQW = 5'd15;

    logic [4:0]  r_st;
    logic [23:0] r_gain;
    logic signed [63:0] r_a [3];
    logic signed [63:0] r_g [3];
    logic signed [63:0] r_q [4];
    logic signed [63:0] r_v [3];
    logic signed [63:0] r_e [3];
    logic signed [63:0] r_s [4];
    logic [23:0] r_dt;
    logic [63:0] r_sum;
    logic [31:0] r_n;
    logic [4:0]  r_k;
    logic signed [63:0] r_acc;
    logic        r_ovalid;
    logic [127:0] r_odata;

    // one shared multiplier with registered product
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] r_prod;
    logic        sq_start, sq_done;
    logic [31:0] sq_root;
    iqau_pkg::t_div_req dreq;
    logic        dv_done;
    logic [63:0] dv_quot;

    iqau_sqrt u_sqrt (.i_clk, .i_rst_n, .i_start(sq_start), .i_val(r_sum),
                      .o_done(sq_done), .o_root(sq_root));
    iqau_div u_div (.i_clk, .i_rst_n, .i_req(dreq), .o_done(dv_done), .o_quot(dv_quot));

    function automatic logic signed [63:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction
    function automatic logic signed [63:0] clampu(input logic signed [63:0] x);
        if (x > 64'sd1073741824) return 64'sd1073741824;
        if (x < -64'sd1073741824) return -64'sd1073741824;
        return x;
    endfunction

    // operand schedule, indexed by step counter r_k within a state
    always_comb begin
        w_ma = '0; w_mb = '0;
        case (r_st)
            S_ASUM: begin w_ma = 33'(r_a[r_k[1:0]]); w_mb = 33'(r_a[r_k[1:0]]); end
            S_V: begin
                case (r_k)
                    5'd0: begin w_ma = 33'(r_q[1]); w_mb = 33'(r_q[3]); end
                    5'd1: begin w_ma = 33'(r_q[0]); w_mb = 33'(r_q[2]); end
                    5'd2: begin w_ma = 33'(r_q[0]); w_mb = 33'(r_q[1]); end
                    5'd3: begin w_ma = 33'(r_q[2]); w_mb = 33'(r_q[3]); end
                    5'd4: begin w_ma = 33'(r_q[0]); w_mb = 33'(r_q[0]); end
                    5'd5: begin w_ma = 33'(r_q[1]); w_mb = 33'(r_q[1]); end
                    5'd6: begin w_ma = 33'(r_q[2]); w_mb = 33'(r_q[2]); end
                    default: begin w_ma = 33'(r_q[3]); w_mb = 33'(r_q[3]); end
                endcase
            end
            S_E: begin
                case (r_k)
                    5'd0: begin w_ma = 33'(r_a[1]); w_mb = 33'(r_v[2]); end
                    5'd1: begin w_ma = 33'(r_a[2]); w_mb = 33'(r_v[1]); end
                    5'd2: begin w_ma = 33'(r_a[2]); w_mb = 33'(r_v[0]); end
                    5'd3: begin w_ma = 33'(r_a[0]); w_mb = 33'(r_v[2]); end
                    5'd4: begin w_ma = 33'(r_a[0]); w_mb = 33'(r_v[1]); end
                    default: begin w_ma = 33'(r_a[1]); w_mb = 33'(r_v[0]); end
                endcase
            end
            S_G: begin w_ma = $signed({9'd0, r_gain}); w_mb = 33'(r_e[r_k[1:0]]); end
            S_S: begin
                case (r_k)
                    5'd0: begin w_ma = 33'(r_g[0]); w_mb = 33'(r_q[1]); end
                    5'd1: begin w_ma = 33'(r_g[1]); w_mb = 33'(r_q[2]); end
                    5'd2: begin w_ma = 33'(r_g[2]); w_mb = 33'(r_q[3]); end
                    5'd3: begin w_ma = 33'(r_g[0]); w_mb = 33'(r_q[0]); end
                    5'd4: begin w_ma = 33'(r_g[2]); w_mb = 33'(r_q[2]); end
                    5'd5: begin w_ma = 33'(r_g[1]); w_mb = 33'(r_q[3]); end
                    5'd6: begin w_ma = 33'(r_g[1]); w_mb = 33'(r_q[0]); end
                    5'd7: begin w_ma = 33'(r_g[2]); w_mb = 33'(r_q[1]); end
                    5'd8: begin w_ma = 33'(r_g[0]); w_mb = 33'(r_q[3]); end
                    5'd9: begin w_ma = 33'(r_g[2]); w_mb = 33'(r_q[0]); end
                    5'd10: begin w_ma = 33'(r_g[1]); w_mb = 33'(r_q[1]); end
                    default: begin w_ma = 33'(r_g[0]); w_mb = 33'(r_q[2]); end
                endcase
            end
            S_INC: begin
                // even step: s above bit 24 times dt, odd step: low 24 bits of s times dt
                w_ma = r_k[0] ? $signed({9'd0, r_s[r_k[2:1]][23:0]})
                              : 33'(r_s[r_k[2:1]] >>> 24);
                w_mb = $signed({9'd0, r_dt});
            end
            S_QSUM: begin w_ma = 33'(r_q[r_k[1:0]]); w_mb = 33'(r_q[r_k[1:0]]); end
            default: ;
        endcase
    end

    // product for step k is registered and lands in the next cycle, consumed with r_k-1
    logic [4:0]  w_km1;
    logic signed [63:0] w_p, w_p30, w_p16;
    assign w_km1 = r_k - 5'd1;
    assign w_p   = r_prod[63:0];
    assign w_p30 = w_p >>> 30;
    assign w_p16 = w_p >>> 16;

    logic [63:0] w_dmag;
    logic signed [63:0] w_dnum;
    logic [1:0]  w_di;
    assign w_di   = r_k[1:0];
    assign w_dnum = (r_st == S_ADIV) ? (r_a[w_di] <<< 40) : (r_q[w_di] <<< 29);
    assign w_dmag = w_dnum[63] ? 64'(-w_dnum) : 64'(w_dnum);
    assign dreq.start   = (r_st == S_ADIV) || (r_st == S_QDIV);
    assign dreq.num_mag = w_dmag;
    assign dreq.den     = {32'd0, r_n};
    assign sq_start     = (r_st == S_ASQ) || (r_st == S_QSQ);

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    logic signed [63:0] w_qn;
    assign w_qn  = dv_quot[63] ? 64'sh7fff_ffff_ffff_ffff : $signed(dv_quot);

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_gain   <= iqau_pkg::GAIN_RESET;
            r_ovalid <= 1'b0;
            r_acc    <= '0;
            r_q[0]   <= 64'(iqau_pkg::ONE_Q30);
            r_q[1]   <= '0;
            r_q[2]   <= '0;
            r_q[3]   <= '0;
        end else begin
            if (i_cfg_we) r_gain <= i_cfg_data;
            if (r_st == S_OUT && (!r_ovalid || m_axis_tready)) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_a[0] <= 64'($signed(s_axis_tdata[15:0]));
                    r_a[1] <= 64'($signed(s_axis_tdata[31:16]));
                    r_a[2] <= 64'($signed(s_axis_tdata[47:32]));
                    r_g[0] <= 64'($signed(s_axis_tdata[79:48]));
                    r_g[1] <= 64'($signed(s_axis_tdata[111:80]));
                    r_g[2] <= 64'($signed(s_axis_tdata[143:112]));
                    r_dt   <= s_axis_tdata[167:144];
                    r_sum  <= '0;
                    r_k    <= '0;
                    r_st   <= S_ASUM;
                end
                S_ASUM: begin
                    if (r_k != 5'd0) r_sum <= r_sum + w_p;
                    r_k <= r_k + 5'd1;
                    if (r_k == 5'd3) begin
                        r_sum <= (r_sum + w_p) << 20;
                        r_st  <= S_ASQ;
                    end
                end
                S_ASQ: r_st <= S_SQW;
                S_SQW: if (sq_done) begin
                    r_n <= sq_root;
                    r_k <= '0;
                    if (r_acc == 64'sd1) begin
                        // zero-norm quaternion: emit unnormalized
                        r_st <= (sq_root == 32'd0) ? S_OUT : S_QDIV;
                    end else if (sq_root == 32'd0) begin
                        r_a[0] <= '0; r_a[1] <= '0; r_a[2] <= '0;
                        r_st <= S_V;
                    end else begin
                        r_st <= S_ADIV;
                    end
                end
                S_ADIV: r_st <= S_ADW;
                S_ADW: if (dv_done) begin
                    r_a[w_di] <= clampu(r_a[w_di][63] ? -w_qn : w_qn);
                    if (w_di == 2'd2) begin
                        r_k <= '0; r_st <= S_V;
                    end else begin
                        r_k <= r_k + 5'd1; r_st <= S_ADIV;
                    end
                end
                S_V: begin
                    r_k <= r_k + 5'd1;
                    case (w_km1)
                        5'd0: r_acc <= w_p30;
                        5'd1: r_v[0] <= sat32((r_acc - w_p30) <<< 1);
                        5'd2: r_acc <= w_p30;
                        5'd3: r_v[1] <= sat32((r_acc + w_p30) <<< 1);
                        5'd4: r_acc <= w_p30;
                        5'd5: r_acc <= r_acc - w_p30;
                        5'd6: r_acc <= r_acc - w_p30;
                        5'd7: begin
                            r_v[2] <= sat32(r_acc + w_p30);
                            r_k <= '0; r_st <= S_E;
                        end
                        default: ;
                    endcase
                end
                S_E: begin
                    r_k <= r_k + 5'd1;
                    case (w_km1)
                        5'd0, 5'd2, 5'd4: r_acc <= w_p30;
                        5'd1: r_e[0] <= sat32(r_acc - w_p30);
                        5'd3: r_e[1] <= sat32(r_acc - w_p30);
                        5'd5: begin
                            r_e[2] <= sat32(r_acc - w_p30);
                            r_k <= '0; r_st <= S_G;
                        end
                        default: ;
                    endcase
                end
                S_G: begin
                    r_k <= r_k + 5'd1;
                    if (r_k != 5'd0) r_g[w_km1[1:0]] <= sat32(r_g[w_km1[1:0]] + w_p30);
                    if (r_k == 5'd3) begin r_k <= '0; r_st <= S_S; end
                end
                S_S: begin
                    r_k <= r_k + 5'd1;
                    case (w_km1)
                        5'd0: r_acc <= -w_p16;
                        5'd1: r_acc <= r_acc - w_p16;
                        5'd2: r_s[0] <= r_acc - w_p16;
                        5'd3: r_acc <= w_p16;
                        5'd4: r_acc <= r_acc + w_p16;
                        5'd5: r_s[1] <= r_acc - w_p16;
                        5'd6: r_acc <= w_p16;
                        5'd7: r_acc <= r_acc - w_p16;
                        5'd8: r_s[2] <= r_acc + w_p16;
                        5'd9: r_acc <= w_p16;
                        5'd10: r_acc <= r_acc + w_p16;
                        5'd11: begin
                            r_s[3] <= r_acc - w_p16;
                            r_k <= '0; r_st <= S_INC;
                        end
                        default: ;
                    endcase
                end
                S_INC: begin
                    r_k <= r_k + 5'd1;
                    if (r_k != 5'd0) begin
                        if (!w_km1[0]) r_acc <= w_p;
                        else begin
                            // floor(s*dt / 2^25) from the two partial products
                            r_q[w_km1[2:1]] <= sat32(r_q[w_km1[2:1]]
                                + ((r_acc + (w_p >>> 24)) >>> 1));
                        end
                    end
                    if (r_k == 5'd8) begin
                        r_k <= '0; r_sum <= '0; r_st <= S_QSUM;
                    end
                end
                S_QSUM: begin
                    r_k <= r_k + 5'd1;
                    if (r_k != 5'd0) r_sum <= r_sum + (w_p >> 2);
                    if (r_k == 5'd4) begin
                        r_acc <= 64'sd1;   // mark the quaternion pass for the root handler
                        r_st <= S_QSQ;
                    end
                end
                S_QSQ: r_st <= S_SQW;
                S_QDIV: r_st <= S_QDW;
                S_QDW: if (dv_done) begin
                    r_q[w_di] <= clampu(r_q[w_di][63] ? -w_qn : w_qn);
                    if (w_di == 2'd3) r_st <= S_OUT;
                    else begin r_k <= r_k + 5'd1; r_st <= S_QDIV; end
                end
                // hold until the output register is free
                S_OUT: if (!r_ovalid || m_axis_tready) begin
                    r_odata  <= {r_q[3][31:0], r_q[2][31:0], r_q[1][31:0], r_q[0][31:0]};
                    r_acc    <= '0;
                    r_st     <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hdl/iqau_sqrt.sv
// Bit-pair serial integer square root, one result bit per cycle.
module iqau_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_rem;
    logic [63:0] r_val;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [65:0] w_trial;
    logic [65:0] w_cur;

    assign w_cur   = {r_rem, r_val[63:62]};
    assign w_trial = w_cur - {32'd0, r_root, 2'b01};
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_val  <= i_val;
                r_root <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_val <= {r_val[61:0], 2'b00};
                if (!w_trial[65]) begin
                    r_rem  <= w_trial[63:0];
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= w_cur[63:0];
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: hdl/iqau_div.sv
// Restoring serial divider, one quotient bit per cycle, unsigned 64/64.
module iqau_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iqau_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [63:0]       o_quot
);
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] w_sh;
    logic [64:0] w_sub;

    assign w_sh   = {r_rem, r_quo[63]};
    assign w_sub  = w_sh - {1'b0, r_den};
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quo  <= i_req.num_mag;
                r_den  <= i_req.den;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (!w_sub[64]) begin
                    r_rem <= w_sub[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_sh[63:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: hdl/iqau_check.sv
// Port-level checker for the attitude update block and its bind.
module iqau_check (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_noin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready && !s_axis_tready |=> !s_axis_tready)
        else $error("input opened while result stalled");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second sample taken during update");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");
endmodule

bind imu_quaternion_attitude_update_top iqau_check u_iqau_check (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata);

FILE: test/tb.sv
// Self-checking testbench for the quaternion attitude update block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum {EV_SAMPLE, EV_GAIN, EV_DRAIN, EV_HOLD, EV_MODE} t_ev_kind;

    typedef struct {
        t_ev_kind           kind;
        logic signed [15:0] ax, ay, az;
        logic signed [31:0] gx, gy, gz;
        logic [23:0]        dt;
        logic [23:0]        gain;
        int                 snd_idle, rcv_idle;
    } t_ev;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [23:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;

    t_ev               pending_q[$];
    logic [127:0]      attitude_q[$];
    t_ev               cur_sample;
    logic signed [31:0] att_model[4];
    logic [23:0]       gain_model;
    bit                taken = 1'b0;
    bit                run_done = 1'b0;
    int                snd_idle = 31, rcv_idle = 69;
    int                settle_cnt = 0;
    int                hold_req = 0, hold_seen = 0, hold_cnt = 0;
    int                errors = 0;

    imu_quaternion_attitude_update_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Divide truncating toward zero.
    function automatic longint div_trunc(longint num, longint unsigned den);
        longint unsigned mag, quo;
        mag = (num < 0) ? (64'd0 - longint'(num)) : longint'(num);
        quo = mag / den;
        return (num < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint clamp_unit(longint x);
        if (x > 64'sd1073741824) return 64'sd1073741824;
        if (x < -64'sd1073741824) return -64'sd1073741824;
        return x;
    endfunction

    function automatic longint mul30(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    // Advance the attitude model by one sample and return the packed quaternion.
    function automatic logic [127:0] update_attitude(t_ev smp);
        longint a[3], g[3], q[4], v[3], e[3], s[4];
        longint hi, lo, inc;
        longint unsigned sum, n, dh, dl;
        a[0] = smp.ax; a[1] = smp.ay; a[2] = smp.az;
        g[0] = smp.gx; g[1] = smp.gy; g[2] = smp.gz;
        for (int i = 0; i < 4; i++) q[i] = att_model[i];
        sum = 0;
        for (int i = 0; i < 3; i++) sum += longint'(a[i] * a[i]);
        n = isqrt64(sum << 20);
        for (int i = 0; i < 3; i++)
            a[i] = (n != 0) ? clamp_unit(div_trunc(a[i] * (64'sd1 <<< 40), n)) : 64'sd0;
        v[0] = sat32(2 * (mul30(q[1], q[3]) - mul30(q[0], q[2])));
        v[1] = sat32(2 * (mul30(q[0], q[1]) + mul30(q[2], q[3])));
        v[2] = sat32(mul30(q[0], q[0]) - mul30(q[1], q[1]) - mul30(q[2], q[2])
                     + mul30(q[3], q[3]));
        e[0] = sat32(mul30(a[1], v[2]) - mul30(a[2], v[1]));
        e[1] = sat32(mul30(a[2], v[0]) - mul30(a[0], v[2]));
        e[2] = sat32(mul30(a[0], v[1]) - mul30(a[1], v[0]));
        for (int i = 0; i < 3; i++)
            g[i] = sat32(g[i] + ((longint'(gain_model) * e[i]) >>> 30));
        s[0] = -((g[0] * q[1]) >>> 16) - ((g[1] * q[2]) >>> 16) - ((g[2] * q[3]) >>> 16);
        s[1] =  ((g[0] * q[0]) >>> 16) + ((g[2] * q[2]) >>> 16) - ((g[1] * q[3]) >>> 16);
        s[2] =  ((g[1] * q[0]) >>> 16) - ((g[2] * q[1]) >>> 16) + ((g[0] * q[3]) >>> 16);
        s[3] =  ((g[2] * q[0]) >>> 16) + ((g[1] * q[1]) >>> 16) - ((g[0] * q[2]) >>> 16);
        dh = smp.dt >> 12;
        dl = smp.dt & 24'hfff;
        for (int i = 0; i < 4; i++) begin
            hi = s[i] * longint'(dh);
            lo = s[i] * longint'(dl);
            inc = (hi + (lo >>> 12)) >>> 13;
            q[i] = sat32(q[i] + inc);
        end
        sum = 0;
        for (int i = 0; i < 4; i++) sum += longint'(q[i] * q[i]) >> 2;
        n = isqrt64(sum);
        if (n != 0)
            for (int i = 0; i < 4; i++) q[i] = clamp_unit(div_trunc(q[i] * (64'sd1 <<< 29), n));
        for (int i = 0; i < 4; i++) att_model[i] = q[i][31:0];
        return {att_model[3], att_model[2], att_model[1], att_model[0]};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic push_sample(int ax, int ay, int az, int gx, int gy, int gz, int dt);
        t_ev ev;
        ev.kind = EV_SAMPLE;
        ev.ax = 16'(ax); ev.ay = 16'(ay); ev.az = 16'(az);
        ev.gx = gx; ev.gy = gy; ev.gz = gz;
        ev.dt = 24'(dt);
        pending_q.push_back(ev);
    endtask

    task automatic push_ctrl(t_ev_kind kind, int gain = 0, int si = 0, int ri = 0);
        t_ev ev;
        ev.kind = kind;
        ev.gain = 24'(gain);
        ev.snd_idle = si;
        ev.rcv_idle = ri;
        pending_q.push_back(ev);
    endtask

    task automatic push_random(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 15)
                push_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom);
            else
                push_sample(int'($urandom_range(0, 8000)) - 4000,
                            int'($urandom_range(0, 8000)) - 4000,
                            int'($urandom_range(0, 8000)) + 12000,
                            int'($urandom_range(0, 524288)) - 262144,
                            int'($urandom_range(0, 524288)) - 262144,
                            int'($urandom_range(0, 524288)) - 262144,
                            $urandom_range(0, 40000));
        end
    endtask

    // Sender: one decision per falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !taken) begin
                i_cfg_we <= 1'b0;
            end else if (settle_cnt > 0) begin
                settle_cnt <= settle_cnt - 1;
                s_axis_tvalid <= 1'b0;
                i_cfg_we <= 1'b0;
            end else if (pending_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                i_cfg_we <= 1'b0;
                if (attitude_q.size() == 0 && !s_axis_tvalid) run_done <= 1'b1;
            end else begin
                case (pending_q[0].kind)
                    EV_SAMPLE: begin
                        i_cfg_we <= 1'b0;
                        if ($urandom_range(99) < snd_idle) begin
                            s_axis_tvalid <= 1'b0;
                        end else begin
                            cur_sample = pending_q.pop_front();
                            s_axis_tdata <= {cur_sample.dt, cur_sample.gz, cur_sample.gy,
                                             cur_sample.gx, cur_sample.az, cur_sample.ay,
                                             cur_sample.ax};
                            s_axis_tvalid <= 1'b1;
                            taken <= 1'b0;
                        end
                    end
                    EV_GAIN: begin
                        s_axis_tvalid <= 1'b0;
                        // Write only once the block has handed over everything.
                        if (attitude_q.size() == 0 && !s_axis_tvalid) begin
                            i_cfg_we <= 1'b1;
                            i_cfg_data <= pending_q[0].gain;
                            gain_model = pending_q[0].gain;
                            void'(pending_q.pop_front());
                            settle_cnt <= 4;
                        end else begin
                            i_cfg_we <= 1'b0;
                        end
                    end
                    EV_DRAIN: begin
                        s_axis_tvalid <= 1'b0;
                        i_cfg_we <= 1'b0;
                        if (attitude_q.size() == 0 && !s_axis_tvalid)
                            void'(pending_q.pop_front());
                    end
                    EV_HOLD: begin
                        s_axis_tvalid <= 1'b0;
                        i_cfg_we <= 1'b0;
                        hold_req++;
                        void'(pending_q.pop_front());
                    end
                    default: begin
                        s_axis_tvalid <= 1'b0;
                        i_cfg_we <= 1'b0;
                        snd_idle = pending_q[0].snd_idle;
                        rcv_idle = pending_q[0].rcv_idle;
                        void'(pending_q.pop_front());
                    end
                endcase
            end
        end
    end

    // Receiver: random stalls plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_cnt = 3000;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    // Input acceptance and output checking.
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready && !taken) begin
                attitude_q.push_back(update_attitude(cur_sample));
                taken <= 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (attitude_q.size() == 0) begin
                    report_mismatch("unexpected att_w", m_axis_tdata[31:0], 32'd0);
                end else begin
                    want = attitude_q.pop_front();
                    if (m_axis_tdata[31:0] !== want[31:0])
                        report_mismatch("att_w", m_axis_tdata[31:0], want[31:0]);
                    if (m_axis_tdata[63:32] !== want[63:32])
                        report_mismatch("att_x", m_axis_tdata[63:32], want[63:32]);
                    if (m_axis_tdata[95:64] !== want[95:64])
                        report_mismatch("att_y", m_axis_tdata[95:64], want[95:64]);
                    if (m_axis_tdata[127:96] !== want[127:96])
                        report_mismatch("att_z", m_axis_tdata[127:96], want[127:96]);
                end
            end
        end
    end

    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        att_model[0] = iqau_pkg::ONE_Q30;
        att_model[1] = 0;
        att_model[2] = 0;
        att_model[3] = 0;
        gain_model = iqau_pkg::GAIN_RESET;

        // Directed: level, zero accel, field extremes, gain extremes.
        push_sample(0, 0, 16384, 0, 0, 0, 16777);
        push_sample(0, 0, 0, 65536, -65536, 32768, 16777);
        push_sample(0, 0, 0, 0, 0, 0, 0);
        push_sample(32767, 0, 0, 0, 0, 0, 16777);
        push_sample(-32768, -32768, -32768, 0, 0, 0, 16777);
        push_sample(32767, 32767, 32767, 2147483647, 2147483647, 2147483647, 16777215);
        push_sample(-32768, 32767, -32768, -2147483648, -2147483648, -2147483648, 16777215);
        push_sample(0, 0, 0, 2147483647, -2147483648, 2147483647, 16777215);
        push_sample(1, 0, 0, 0, 0, 0, 1);
        push_sample(0, -1, 0, -1, 1, -1, 16777215);
        push_ctrl(EV_GAIN, 0);
        push_sample(1000, -2000, 15000, 131072, 0, -131072, 20000);
        push_sample(-32768, 0, 0, 0, 0, 0, 16777215);
        push_ctrl(EV_GAIN, 24'hffffff);
        push_sample(16000, 16000, 0, 0, 0, 0, 16777215);
        push_sample(0, 0, -32768, 1000000, -1000000, 0, 16777215);
        push_sample(-5000, 12000, 3000, 0, 0, 0, 65536);
        push_sample(0, 0, 0, 0, 0, 0, 16777215);
        push_ctrl(EV_GAIN, iqau_pkg::GAIN_RESET);
        push_sample(0, 0, 16384, 0, 0, 0, 16777);

        push_ctrl(EV_MODE, 0, 31, 69);
        push_random(200);
        push_ctrl(EV_HOLD);
        push_random(30);
        push_ctrl(EV_DRAIN);
        push_ctrl(EV_GAIN, $urandom_range(0, 24'hffffff));
        push_random(190);
        push_ctrl(EV_MODE, 0, 69, 31);
        push_random(200);
        push_ctrl(EV_GAIN, 24'hffffff);
        push_random(200);
        push_ctrl(EV_MODE, 0, 0, 0);
        push_ctrl(EV_GAIN, 0);
        push_random(200);
        push_ctrl(EV_GAIN, $urandom_range(0, 24'h0fffff));
        push_random(230);

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (run_done);
        repeat (800) @(posedge i_clk);
        if (errors == 0 && attitude_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hdl/iqau_pkg.sv
hdl/iqau_sqrt.sv
hdl/iqau_div.sv
hdl/imu_quaternion_attitude_update_top.sv
hdl/iqau_check.sv
test/tb.sv
